@@ sv/stks_pkg.sv @@
`default_nettype none

package stks_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W           = 64;
    localparam int POS_W           = 10;
    localparam int LEN_W           = 11;
    localparam int CFG_IDX_W       = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LENGTH = 1'b0,
        CFG_SEARCH_MODE  = 1'b1
    } cfg_idx_t;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_SEARCH  = 1'b1;
    localparam logic MODE_BINARY = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    // Microprogram addresses.
    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_B_CHECK = 3'd1,
        S_B_STEP  = 3'd2,
        S_B_FIN   = 3'd3,
        S_L_READ  = 3'd4,
        S_L_TEST  = 3'd5,
        S_EMIT    = 3'd6
    } step_t;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_IDLE     = 3'd0,
        OP_B_READ   = 3'd1,
        OP_B_NARROW = 3'd2,
        OP_B_FINISH = 3'd3,
        OP_L_READ   = 3'd4,
        OP_L_TEST   = 3'd5,
        OP_EMIT     = 3'd6
    } op_t;

    // Jump condition; the jump target is taken when it holds, else the sequential one.
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_DISPATCH = 3'd1,
        C_LO_GE_HI = 3'd2,
        C_IDX_GE_N = 3'd3,
        C_MISS     = 3'd4,
        C_RES_BUSY = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp;
        step_t seq;
    } uword_t;

    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        case (s)
            S_IDLE:    w = '{op: OP_IDLE,     cond: C_DISPATCH, jmp: S_IDLE,    seq: S_IDLE};
            S_B_CHECK: w = '{op: OP_B_READ,   cond: C_LO_GE_HI, jmp: S_B_FIN,   seq: S_B_STEP};
            S_B_STEP:  w = '{op: OP_B_NARROW, cond: C_ALWAYS,   jmp: S_B_CHECK, seq: S_B_CHECK};
            S_B_FIN:   w = '{op: OP_B_FINISH, cond: C_ALWAYS,   jmp: S_EMIT,    seq: S_EMIT};
            S_L_READ:  w = '{op: OP_L_READ,   cond: C_IDX_GE_N, jmp: S_EMIT,    seq: S_L_TEST};
            S_L_TEST:  w = '{op: OP_L_TEST,   cond: C_MISS,     jmp: S_L_READ,  seq: S_EMIT};
            S_EMIT:    w = '{op: OP_EMIT,     cond: C_RES_BUSY, jmp: S_EMIT,    seq: S_IDLE};
            default:   w = '{op: OP_IDLE,     cond: C_ALWAYS,   jmp: S_IDLE,    seq: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/stks_if.sv @@
`default_nettype none

interface stks_req_if;
    import stks_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [POS_W-1:0]        write_index;
    logic signed [KEY_W-1:0] write_key;
    logic signed [KEY_W-1:0] search_key;

    modport source (output valid, cmd, write_index, write_key, search_key, input ready);
    modport sink   (input valid, cmd, write_index, write_key, search_key, output ready);
endinterface

interface stks_res_if;
    import stks_pkg::*;
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

@@ sv/stks_table.sv @@
`default_nettype none

module stks_table
    import stks_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [KEY_W-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [KEY_W-1:0] rdata
);

    // Single write port, single registered read port; contents undefined until written.
    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/sorted_table_key_search.sv @@
// Write requests may follow back to back; they give no result.
// Binary search: an accept step, then a memory read and a narrowing step per table probe,
// then steps to read, check and post the result.
// Linear search: a read and a test step per entry; the single memory read port paces both.
// Reset clears the sequencer, the result slot and both configuration registers.
// The key table has no reset and no clearing pass; entries are undefined until written.
`default_nettype none

module sorted_table_key_search
    import stks_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data,
    stks_req_if.sink                  req,
    stks_res_if.source                res
);

    // AW addresses the table; CW counts up to and including the table depth.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Configuration registers.
    logic [LEN_W-1:0] table_length_reg;
    logic             search_mode_reg;

    // Sequencer: the step counter addresses the control store.
    step_t  upc_reg, upc_next;
    uword_t uw;

    // Datapath registers for the request in flight.
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [AW-1:0]           lo_reg, lo_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    hit_reg, hit_next;
    logic [AW-1:0]           pos_reg, pos_next;

    // Output slot. It lets the sequencer take the next request while a result waits.
    logic             res_valid_reg, res_valid_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] position_reg, position_next;

    // Decoded handshake and datapath terms.
    logic                    req_fire;
    logic                    is_search;
    logic                    is_write;
    logic [31:0]             widx32;
    logic [31:0]             len32;
    logic [31:0]             pos32;
    logic [CW-1:0]           n_new;
    logic [AW:0]             sum;
    logic [AW-1:0]           mid;
    logic                    lo_lt_hi;
    logic                    idx_lt_n;
    logic                    rd_hit;
    logic                    key_le;
    logic                    res_free;
    logic                    cond_true;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [KEY_W-1:0] rd_data;

    // The current control word drives everything below.
    assign uw = ucode_rom(upc_reg);

    // Requests are taken only at the idle step of the program.
    assign req.ready = (uw.op == OP_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign is_search = req_fire && (req.cmd == CMD_SEARCH);
    assign is_write  = req_fire && (req.cmd == CMD_WRITE);

    // A write outside the table is dropped.
    assign widx32    = 32'(req.write_index);
    assign mem_we    = is_write && (widx32 < 32'(TABLE_DEPTH));
    assign mem_waddr = widx32[AW-1:0];

    // The length in use saturates at the table depth.
    assign len32 = 32'(table_length_reg);
    assign n_new = CW'((len32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len32);

    // Binary search midpoint, rounded down, and the loop tests.
    assign sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = sum[AW:1];
    assign lo_lt_hi = (lo_reg < hi_reg);
    assign idx_lt_n = (idx_reg < n_reg);

    // Comparisons against the entry read in the previous step; both operands are signed.
    assign rd_hit = (rd_data == key_reg);
    assign key_le = (key_reg <= rd_data);

    assign res_free = !res_valid_reg || res.ready;

    assign pos32 = 32'(pos_reg);

    // Memory read port. The binary probe reads the midpoint while the range is open and
    // the final lower-bound entry once it has closed.
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (uw.op)
            OP_B_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = lo_lt_hi ? mid : lo_reg;
            end
            OP_L_READ:
            begin
                mem_re    = idx_lt_n;
                mem_raddr = idx_reg[AW-1:0];
            end
            default:
            begin
                mem_re    = 1'b0;
                mem_raddr = '0;
            end
        endcase
    end

    stks_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.write_key),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    // Jump condition of the current control word.
    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_LO_GE_HI: cond_true = !lo_lt_hi;
            C_IDX_GE_N: cond_true = !idx_lt_n;
            C_MISS:     cond_true = !rd_hit;
            C_RES_BUSY: cond_true = !res_free;
            default:    cond_true = 1'b0;
        endcase
    end

    // Next step. The idle word dispatches on the request: an empty table goes straight
    // to the result with not found at position zero.
    always_comb
    begin
        if (uw.cond == C_DISPATCH)
        begin
            if (!is_search)
            begin
                upc_next = S_IDLE;
            end
            else if (n_new == '0)
            begin
                upc_next = S_EMIT;
            end
            else if (search_mode_reg == MODE_BINARY)
            begin
                upc_next = S_B_CHECK;
            end
            else
            begin
                upc_next = S_L_READ;
            end
        end
        else
        begin
            upc_next = cond_true ? uw.jmp : uw.seq;
        end
    end

    // Datapath updates selected by the control word.
    always_comb
    begin
        key_next = key_reg;
        n_next   = n_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        pos_next = pos_reg;
        case (uw.op)
            OP_IDLE:
            begin
                if (is_search)
                begin
                    key_next = req.search_key;
                    n_next   = n_new;
                    lo_next  = '0;
                    hi_next  = AW'(n_new - CW'(1));
                    idx_next = '0;
                    hit_next = 1'b0;
                    pos_next = '0;
                end
            end
            OP_B_READ:
            begin
                mid_next = mid;
            end
            OP_B_NARROW:
            begin
                if (key_le)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + AW'(1);
                end
            end
            OP_B_FINISH:
            begin
                hit_next = rd_hit;
                pos_next = lo_reg;
            end
            OP_L_TEST:
            begin
                if (rd_hit)
                begin
                    hit_next = 1'b1;
                    pos_next = idx_reg[AW-1:0];
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // Result slot: loaded at the emit step once it is free, emptied when taken.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        if ((uw.op == OP_EMIT) && res_free)
        begin
            res_valid_next = 1'b1;
            found_next     = hit_reg;
            position_next  = pos32[POS_W-1:0];
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.found    = found_reg;
    assign res.position = position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
            search_mode_reg  <= MODE_BINARY;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TABLE_LENGTH)
            begin
                table_length_reg <= cfg_data;
            end
            else
            begin
                search_mode_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    // The binary range never inverts while the probe loop runs.
    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_B_CHECK) |-> (lo_reg <= hi_reg))
        else $error("binary search range inverted");

    // A narrowing step always follows a midpoint read.
    a_narrow_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_B_STEP) |-> ($past(upc_reg) == S_B_CHECK))
        else $error("narrowing step without a preceding probe");

    // The linear scan only tests entries inside the length in use.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == S_L_TEST) |-> (idx_reg < n_reg))
        else $error("linear scan past the table length");

    // Leaving the emit step always leaves a result in the output slot.
    a_emit_posts: assert property (@(posedge clk) disable iff (!rst_n)
        ((upc_reg == S_EMIT) && res_free) |=> res_valid_reg)
        else $error("emit step finished without posting a result");

endmodule

`default_nettype wire
